// File: design/dcf_pkg.sv
// Shared types and constants for the disk contact force unit.
`timescale 1ns / 1ps

package dcf_pkg;

	localparam int CFG_W       = 32;
	localparam int REG_INDEX_W = 1;
	localparam int FORCE_W     = 48;

	localparam int DIFF_W      = 33;   // exact difference of two Q8.24 values
	localparam int RAD_W       = 66;   // dx*dx + dy*dy
	localparam int ROOT_W      = 33;   // centre distance
	localparam int NORM_W      = 31;   // unit normal magnitude, Q1.30
	localparam int SQRT_STAGES = ROOT_W;
	localparam int DIV_STAGES  = NORM_W;

	localparam logic [CFG_W-1:0] SPRING_RESET  = 32'd65536;
	localparam logic [CFG_W-1:0] DAMPING_RESET = 32'd0;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_SPRING  = 1'b0,
		REG_DAMPING = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic signed [31:0] first_pos_x;
		logic signed [31:0] first_pos_y;
		logic signed [31:0] first_vel_x;
		logic signed [31:0] first_vel_y;
		logic [30:0]        first_radius;
		logic signed [31:0] second_pos_x;
		logic signed [31:0] second_pos_y;
		logic signed [31:0] second_vel_x;
		logic signed [31:0] second_vel_y;
		logic [30:0]        second_radius;
	} pair_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] force_x;
		logic signed [FORCE_W-1:0] force_y;
		logic                      in_contact;
		logic                      coincident;
		logic                      saturated;
	} result_t;

	// classified item handed from front to back (differences in two's complement)
	typedef struct packed {
		logic [DIFF_W-1:0] dx;
		logic [DIFF_W-1:0] dy;
		logic [DIFF_W-1:0] dvx;
		logic [DIFF_W-1:0] dvy;
		logic [31:0]       rsum;
		logic              coinc;
	} qitem_t;

endpackage

// File: design/disk_contact_force.sv
// Throughput: one pair item per cycle; the 33-stage root and 31-stage divider are fully
// pipelined, and a stalled result freezes the back pipeline while the queue keeps filling.
// Reset: arst_n clears all valid state and the queue, and sets stiffness to 1.0, damping 0.
// Top level of the disk contact force unit.
`timescale 1ns / 1ps

module disk_contact_force #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pair_valid,
	output logic                            pair_stall,
	input  dcf_pkg::pair_t                  pair,
	output logic                            res_valid,
	input  logic                            res_stall,
	output dcf_pkg::result_t                res,
	input  logic                            cfg_wr_en,
	input  logic [dcf_pkg::REG_INDEX_W-1:0] cfg_index,
	input  logic [dcf_pkg::CFG_W-1:0]       cfg_data
);
	import dcf_pkg::*;

	logic [CFG_W-1:0] spring_q;
	logic [CFG_W-1:0] damp_q;
	logic             q_full;
	logic             q_empty;
	logic             push;
	logic             pop;
	qitem_t           push_item;
	qitem_t           pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_q <= SPRING_RESET;
			damp_q   <= DAMPING_RESET;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_SPRING: begin
					spring_q <= cfg_data;
				end
				REG_DAMPING: begin
					damp_q <= cfg_data;
				end
			endcase
		end
	end

	dcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.pair       (pair),
		.q_full     (q_full),
		.push       (push),
		.item       (push_item)
	);

	dcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	dcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop       (pop),
		.item      (pop_item),
		.spring_k  (spring_q),
		.damp_c    (damp_q),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// File: design/dcf_front.sv
// Front end: takes pair items, forms the differences and flags coincident centres.
`timescale 1ns / 1ps

module dcf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pair_valid,
	output logic           pair_stall,
	input  dcf_pkg::pair_t pair,
	input  logic           q_full,
	output logic           push,
	output dcf_pkg::qitem_t item
);
	import dcf_pkg::*;

	logic   vld_s1;
	qitem_t item_s1;
	qitem_t item_d;
	logic   load;

	assign pair_stall = vld_s1 && q_full;
	assign load       = pair_valid && !pair_stall;
	assign push       = vld_s1 && !q_full;
	assign item       = item_s1;

	always_comb begin
		item_d.dx    = {pair.second_pos_x[31], pair.second_pos_x}
		             - {pair.first_pos_x[31], pair.first_pos_x};
		item_d.dy    = {pair.second_pos_y[31], pair.second_pos_y}
		             - {pair.first_pos_y[31], pair.first_pos_y};
		item_d.dvx   = {pair.second_vel_x[31], pair.second_vel_x}
		             - {pair.first_vel_x[31], pair.first_vel_x};
		item_d.dvy   = {pair.second_vel_y[31], pair.second_vel_y}
		             - {pair.first_vel_y[31], pair.first_vel_y};
		item_d.rsum  = {1'b0, pair.first_radius} + {1'b0, pair.second_radius};
		item_d.coinc = (item_d.dx == '0) && (item_d.dy == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_d;
		end
	end

endmodule

// File: design/dcf_queue.sv
// Short queue between the front end and the force pipeline.
`timescale 1ns / 1ps

module dcf_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dcf_pkg::qitem_t push_item,
	output logic            full,
	input  logic            pop,
	output dcf_pkg::qitem_t pop_item,
	output logic            empty
);
	import dcf_pkg::*;

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qitem_t           slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// File: design/dcf_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module dcf_isqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [dcf_pkg::RAD_W-1:0]  radicand,
	output logic [dcf_pkg::ROOT_W-1:0] root
);
	import dcf_pkg::*;

	logic [RAD_W-1:0]  rem_q   [SQRT_STAGES];
	logic [ROOT_W-1:0] root_q  [SQRT_STAGES];
	logic [RAD_W-1:0]  rem_in  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_in [SQRT_STAGES];
	logic [RAD_W-1:0]  rem_nx  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_nx [SQRT_STAGES];

	always_comb begin
		int b;
		logic [RAD_W+1:0] trial;
		rem_in[0]  = radicand;
		root_in[0] = '0;
		for (int i = 1; i < SQRT_STAGES; i++) begin
			rem_in[i]  = rem_q[i-1];
			root_in[i] = root_q[i-1];
		end
		for (int i = 0; i < SQRT_STAGES; i++) begin
			b = SQRT_STAGES - 1 - i;
			// (2r + 2^b) * 2^b against the remaining radicand
			trial = ({{(RAD_W + 2 - ROOT_W){1'b0}}, root_in[i]} << (b + 1))
			      + ((RAD_W + 2)'(1) << (2 * b));
			if (trial <= {2'b00, rem_in[i]}) begin
				rem_nx[i]  = rem_in[i] - trial[RAD_W-1:0];
				root_nx[i] = root_in[i] | (ROOT_W'(1) << b);
			end else begin
				rem_nx[i]  = rem_in[i];
				root_nx[i] = root_in[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < SQRT_STAGES; i++) begin
				rem_q[i]  <= rem_nx[i];
				root_q[i] <= root_nx[i];
			end
		end
	end

	assign root = root_q[SQRT_STAGES-1];

endmodule

// File: design/dcf_div.sv
// Pipelined restoring divider: floor(num * 2^30 / den), for num <= den.
`timescale 1ns / 1ps

module dcf_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [dcf_pkg::DIFF_W-1:0] num,
	input  logic [dcf_pkg::ROOT_W-1:0] den,
	output logic [dcf_pkg::NORM_W-1:0] quo
);
	import dcf_pkg::*;

	logic [ROOT_W-1:0] rem_q  [DIV_STAGES];
	logic [ROOT_W-1:0] den_q  [DIV_STAGES];
	logic [NORM_W-1:0] quo_q  [DIV_STAGES];
	logic [ROOT_W-1:0] rem_in [DIV_STAGES];
	logic [ROOT_W-1:0] den_in [DIV_STAGES];
	logic [NORM_W-1:0] quo_in [DIV_STAGES];
	logic [ROOT_W-1:0] rem_nx [DIV_STAGES];
	logic [NORM_W-1:0] quo_nx [DIV_STAGES];

	always_comb begin
		logic [ROOT_W:0] t;
		logic            ge;
		// numerator is shifted up by 30; the top part already lies below den
		rem_in[0] = {1'b0, num[DIFF_W-1:1]};
		den_in[0] = den;
		quo_in[0] = '0;
		for (int j = 1; j < DIV_STAGES; j++) begin
			rem_in[j] = rem_q[j-1];
			den_in[j] = den_q[j-1];
			quo_in[j] = quo_q[j-1];
		end
		for (int j = 0; j < DIV_STAGES; j++) begin
			t  = {rem_in[j], (j == 0) ? num[0] : 1'b0};
			ge = (t >= {1'b0, den_in[j]});
			rem_nx[j] = ge ? ROOT_W'(t - {1'b0, den_in[j]}) : t[ROOT_W-1:0];
			quo_nx[j] = {quo_in[j][NORM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DIV_STAGES; j++) begin
				rem_q[j] <= rem_nx[j];
				den_q[j] <= den_in[j];
				quo_q[j] <= quo_nx[j];
			end
		end
	end

	assign quo = quo_q[DIV_STAGES-1];

endmodule

// File: design/dcf_back.sv
// Back end: distance, overlap, unit normal and spring-dashpot force pipeline.
`timescale 1ns / 1ps

module dcf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	output logic                      pop,
	input  dcf_pkg::qitem_t           item,
	input  logic [dcf_pkg::CFG_W-1:0] spring_k,
	input  logic [dcf_pkg::CFG_W-1:0] damp_c,
	output logic                      res_valid,
	input  logic                      res_stall,
	output dcf_pkg::result_t          res
);
	import dcf_pkg::*;

	typedef struct packed {
		logic              dx_neg;
		logic              dy_neg;
		logic [DIFF_W-1:0] dx_mag;
		logic [DIFF_W-1:0] dy_mag;
		logic [DIFF_W-1:0] dvx;
		logic [DIFF_W-1:0] dvy;
		logic [31:0]       rsum;
		logic              coinc;
	} side_t;

	typedef struct packed {
		logic              dx_neg;
		logic              dy_neg;
		logic [DIFF_W-1:0] dvx;
		logic [DIFF_W-1:0] dvy;
		logic [31:0]       ov;
		logic              contact;
		logic              coinc;
	} side2_t;

	typedef struct packed {
		logic              contact;
		logic              coinc;
		logic              dx_neg;
		logic              dy_neg;
		logic [NORM_W-1:0] nx;
		logic [NORM_W-1:0] ny;
	} tail_t;

	function automatic logic [FORCE_W:0] clip_force(input logic neg, input logic [54:0] m);
		logic [FORCE_W-1:0] v;
		logic               sat;
		v   = neg ? FORCE_W'(55'd0 - m) : m[FORCE_W-1:0];
		sat = 1'b0;
		if (!neg && m > 55'(48'h7FFF_FFFF_FFFF)) begin
			v   = {1'b0, {(FORCE_W - 1){1'b1}}};
			sat = 1'b1;
		end else if (neg && m > 55'(48'h8000_0000_0000)) begin
			v   = {1'b1, {(FORCE_W - 1){1'b0}}};
			sat = 1'b1;
		end
		return {sat, v};
	endfunction

	logic en;

	// stages before the root
	logic             vld_s1, vld_s2, vld_s3;
	side_t            side_s1, side_s2, side_s3;
	logic [RAD_W-1:0] sqx_s2, sqy_s2, n_s3;

	// aligned with the root and divider pipelines
	logic              vld_sq_q  [SQRT_STAGES];
	side_t             side_sq_q [SQRT_STAGES];
	logic              vld_dv_q  [DIV_STAGES];
	side2_t            side_dv_q [DIV_STAGES];
	logic [ROOT_W-1:0] root;
	logic [NORM_W-1:0] nx_mag, ny_mag;
	side_t             sq_out;
	side2_t            side2_d;
	logic [ROOT_W:0]   ov_d;

	// force stages
	logic        vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	tail_t       tail_s4, tail_s5, tail_s6, tail_s7, tail_s8;
	logic [63:0] pvx_s4, pvy_s4, kov_s4;
	logic        svx_s4, svy_s4;
	logic [35:0] vn_s5;
	logic [47:0] spring_s5, spring_s6;
	logic [66:0] damp_prod_s6;
	logic        damp_neg_s6;
	logic [53:0] fs_s7;
	logic [57:0] pxl_s8, pxh_s8, pyl_s8, pyh_s8;
	logic        sfx_s8, sfy_s8;
	result_t     res_s9;

	logic [DIFF_W-1:0] dvx_mag, dvy_mag;
	logic [33:0]       vx_mag, vy_mag;
	logic [35:0]       vx_t, vy_t, vn_mag;
	logic [50:0]       damp;
	logic [53:0]       damp_t, fs_mag;
	logic [84:0]       mx_sum, my_sum;
	logic [FORCE_W:0]  cx, cy;

	assign en        = !(vld_s9 && res_stall);
	assign pop       = !q_empty && en;
	assign res_valid = vld_s9;
	assign res       = res_s9;

	dcf_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (n_s3),
		.root     (root)
	);

	always_comb begin
		sq_out          = side_sq_q[SQRT_STAGES-1];
		ov_d            = {2'b00, sq_out.rsum} - {1'b0, root};
		side2_d.dx_neg  = sq_out.dx_neg;
		side2_d.dy_neg  = sq_out.dy_neg;
		side2_d.dvx     = sq_out.dvx;
		side2_d.dvy     = sq_out.dvy;
		side2_d.ov      = ov_d[31:0];
		side2_d.contact = !ov_d[ROOT_W] && (ov_d != '0) && (root != '0);
		side2_d.coinc   = sq_out.coinc;
	end

	dcf_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (sq_out.dx_mag),
		.den (root),
		.quo (nx_mag)
	);

	dcf_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (sq_out.dy_mag),
		.den (root),
		.quo (ny_mag)
	);

	always_comb begin
		dvx_mag = side_dv_q[DIV_STAGES-1].dvx[DIFF_W-1]
		        ? DIFF_W'(0) - side_dv_q[DIV_STAGES-1].dvx : side_dv_q[DIV_STAGES-1].dvx;
		dvy_mag = side_dv_q[DIV_STAGES-1].dvy[DIFF_W-1]
		        ? DIFF_W'(0) - side_dv_q[DIV_STAGES-1].dvy : side_dv_q[DIV_STAGES-1].dvy;
		vx_mag  = pvx_s4[63:30];
		vy_mag  = pvy_s4[63:30];
		vx_t    = svx_s4 ? 36'd0 - {2'b00, vx_mag} : {2'b00, vx_mag};
		vy_t    = svy_s4 ? 36'd0 - {2'b00, vy_mag} : {2'b00, vy_mag};
		vn_mag  = vn_s5[35] ? 36'd0 - vn_s5 : vn_s5;
		damp    = damp_prod_s6[66:16];
		damp_t  = damp_neg_s6 ? 54'd0 - {3'b000, damp} : {3'b000, damp};
		fs_mag  = fs_s7[53] ? 54'd0 - fs_s7 : fs_s7;
		mx_sum  = {pxh_s8, 27'd0} + 85'(pxl_s8);
		my_sum  = {pyh_s8, 27'd0} + 85'(pyl_s8);
		cx      = clip_force(sfx_s8, mx_sum[84:30]);
		cy      = clip_force(sfy_s8, my_sum[84:30]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int i = 0; i < SQRT_STAGES; i++) begin
				vld_sq_q[i] <= 1'b0;
			end
			for (int j = 0; j < DIV_STAGES; j++) begin
				vld_dv_q[j] <= 1'b0;
			end
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1      <= pop;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_sq_q[0] <= vld_s3;
			for (int i = 1; i < SQRT_STAGES; i++) begin
				vld_sq_q[i] <= vld_sq_q[i-1];
			end
			vld_dv_q[0] <= vld_sq_q[SQRT_STAGES-1];
			for (int j = 1; j < DIV_STAGES; j++) begin
				vld_dv_q[j] <= vld_dv_q[j-1];
			end
			vld_s4 <= vld_dv_q[DIV_STAGES-1];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.dx_neg <= item.dx[DIFF_W-1];
			side_s1.dy_neg <= item.dy[DIFF_W-1];
			side_s1.dx_mag <= item.dx[DIFF_W-1] ? DIFF_W'(0) - item.dx : item.dx;
			side_s1.dy_mag <= item.dy[DIFF_W-1] ? DIFF_W'(0) - item.dy : item.dy;
			side_s1.dvx    <= item.dvx;
			side_s1.dvy    <= item.dvy;
			side_s1.rsum   <= item.rsum;
			side_s1.coinc  <= item.coinc;

			side_s2 <= side_s1;
			sqx_s2  <= RAD_W'(side_s1.dx_mag) * RAD_W'(side_s1.dx_mag);
			sqy_s2  <= RAD_W'(side_s1.dy_mag) * RAD_W'(side_s1.dy_mag);

			side_s3 <= side_s2;
			n_s3    <= sqx_s2 + sqy_s2;

			side_sq_q[0] <= side_s3;
			for (int i = 1; i < SQRT_STAGES; i++) begin
				side_sq_q[i] <= side_sq_q[i-1];
			end
			side_dv_q[0] <= side2_d;
			for (int j = 1; j < DIV_STAGES; j++) begin
				side_dv_q[j] <= side_dv_q[j-1];
			end

			pvx_s4          <= 64'(dvx_mag) * 64'(nx_mag);
			pvy_s4          <= 64'(dvy_mag) * 64'(ny_mag);
			svx_s4          <= side_dv_q[DIV_STAGES-1].dvx[DIFF_W-1] ^ side_dv_q[DIV_STAGES-1].dx_neg;
			svy_s4          <= side_dv_q[DIV_STAGES-1].dvy[DIFF_W-1] ^ side_dv_q[DIV_STAGES-1].dy_neg;
			kov_s4          <= 64'(spring_k) * 64'(side_dv_q[DIV_STAGES-1].ov);
			tail_s4.contact <= side_dv_q[DIV_STAGES-1].contact;
			tail_s4.coinc   <= side_dv_q[DIV_STAGES-1].coinc;
			tail_s4.dx_neg  <= side_dv_q[DIV_STAGES-1].dx_neg;
			tail_s4.dy_neg  <= side_dv_q[DIV_STAGES-1].dy_neg;
			tail_s4.nx      <= nx_mag;
			tail_s4.ny      <= ny_mag;

			tail_s5   <= tail_s4;
			vn_s5     <= vx_t + vy_t;
			spring_s5 <= kov_s4[63:16];

			tail_s6      <= tail_s5;
			spring_s6    <= spring_s5;
			damp_neg_s6  <= vn_s5[35];
			damp_prod_s6 <= 67'(damp_c) * 67'(vn_mag[34:0]);

			tail_s7 <= tail_s6;
			fs_s7   <= {6'd0, spring_s6} - damp_t;

			// |fs| is split in halves to keep each product narrow
			tail_s8 <= tail_s7;
			pxl_s8  <= 58'(fs_mag[26:0]) * 58'(tail_s7.nx);
			pxh_s8  <= 58'(fs_mag[53:27]) * 58'(tail_s7.nx);
			pyl_s8  <= 58'(fs_mag[26:0]) * 58'(tail_s7.ny);
			pyh_s8  <= 58'(fs_mag[53:27]) * 58'(tail_s7.ny);
			sfx_s8  <= fs_s7[53] ^ tail_s7.dx_neg;
			sfy_s8  <= fs_s7[53] ^ tail_s7.dy_neg;

			res_s9.force_x    <= tail_s8.contact ? cx[FORCE_W-1:0] : '0;
			res_s9.force_y    <= tail_s8.contact ? cy[FORCE_W-1:0] : '0;
			res_s9.in_contact <= tail_s8.contact;
			res_s9.coincident <= tail_s8.coinc;
			res_s9.saturated  <= tail_s8.contact && (cx[FORCE_W] || cy[FORCE_W]);
		end
	end

`ifndef NO_ASSERTIONS
	a_coinc_no_force: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.coincident |-> !res.in_contact && res.force_x == '0
			&& res.force_y == '0)
		else $error("coincident item carries a force");

	a_sat_needs_contact: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.saturated |-> res.in_contact)
		else $error("saturation flagged without contact");
`endif

endmodule

// File: tb/dcf_checker.sv
// Checker for the disk contact force unit: predicts each pair result and compares it.
`timescale 1ns / 1ps

module dcf_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pair_valid,
	input  logic                            pair_stall,
	input  dcf_pkg::pair_t                  pair,
	input  logic                            res_valid,
	input  logic                            res_stall,
	input  dcf_pkg::result_t                res,
	input  logic                            cfg_wr_en,
	input  logic [dcf_pkg::REG_INDEX_W-1:0] cfg_index,
	input  logic [dcf_pkg::CFG_W-1:0]       cfg_data,
	output int                              errors,
	output int                              pending
);
	import dcf_pkg::*;

	localparam longint FORCE_HI = 64'sd140737488355327;
	localparam longint FORCE_LO = -64'sd140737488355328;

	logic [CFG_W-1:0] stiffness;
	logic [CFG_W-1:0] damping;
	result_t          force_q[$];

	// floor(a*b / 2^sh), pinned to all ones when it does not fit 64 bits
	function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] prod;
		logic [127:0] shifted;
		prod    = {64'd0, a} * {64'd0, b};
		shifted = prod >> sh;
		if (shifted[127:64] != 0)
			return '1;
		return shifted[63:0];
	endfunction

	function automatic logic [63:0] magnitude(longint x);
		return x < 0 ? 64'(-x) : 64'(x);
	endfunction

	function automatic longint apply_sign(bit neg, logic [63:0] m);
		if (m > (64'd1 << 62))
			m = 64'd1 << 62;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint signed_scale(longint a, longint b, int sh);
		return apply_sign((a < 0) != (b < 0), mul_shift(magnitude(a), magnitude(b), sh));
	endfunction

	function automatic longint clip_force(longint v, ref bit sat);
		if (v > FORCE_HI) begin
			sat = 1'b1;
			return FORCE_HI;
		end
		if (v < FORCE_LO) begin
			sat = 1'b1;
			return FORCE_LO;
		end
		return v;
	endfunction

	function automatic result_t contact_force(pair_t p);
		longint       dx, dy, dvx, dvy, rsum, ov, nx, ny, vn, spring, damp, fs, fx, fy;
		logic [63:0]  ax, ay, span;
		logic [127:0] sq, cand;
		bit           sat;
		result_t      r;
		r   = '0;
		sat = 1'b0;
		dx   = longint'(p.second_pos_x) - longint'(p.first_pos_x);
		dy   = longint'(p.second_pos_y) - longint'(p.first_pos_y);
		dvx  = longint'(p.second_vel_x) - longint'(p.first_vel_x);
		dvy  = longint'(p.second_vel_y) - longint'(p.first_vel_y);
		rsum = longint'({33'd0, p.first_radius}) + longint'({33'd0, p.second_radius});
		if (dx == 0 && dy == 0) begin
			r.coincident = 1'b1;
			return r;
		end
		ax   = magnitude(dx);
		ay   = magnitude(dy);
		sq   = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
		span = 0;
		for (int b = 32; b >= 0; b--) begin
			cand = {64'd0, span | (64'd1 << b)};
			if (cand * cand <= sq)
				span = cand[63:0];
		end
		ov = rsum - longint'(span);
		if (ov > 0 && span != 0) begin
			r.in_contact = 1'b1;
			nx     = apply_sign(dx < 0, (ax << 30) / span);
			ny     = apply_sign(dy < 0, (ay << 30) / span);
			vn     = signed_scale(dvx, nx, 30) + signed_scale(dvy, ny, 30);
			spring = longint'(mul_shift({32'd0, stiffness}, 64'(ov), 16));
			damp   = signed_scale(longint'({32'd0, damping}), vn, 16);
			fs     = spring - damp;
			fx     = clip_force(signed_scale(fs, nx, 30), sat);
			fy     = clip_force(signed_scale(fs, ny, 30), sat);
			r.force_x   = fx[FORCE_W-1:0];
			r.force_y   = fy[FORCE_W-1:0];
			r.saturated = sat;
		end
		return r;
	endfunction

	assign pending = force_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			stiffness = SPRING_RESET;
			damping   = DAMPING_RESET;
			force_q.delete();
			errors    = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (force_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %p", res);
				end else begin
					want = force_q.pop_front();
					if (res.force_x !== want.force_x || res.force_y !== want.force_y ||
							res.in_contact !== want.in_contact ||
							res.coincident !== want.coincident ||
							res.saturated !== want.saturated) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p, got %p", want, res);
					end
				end
			end
			if (cfg_wr_en) begin
				if (reg_index_t'(cfg_index) == REG_SPRING)
					stiffness = cfg_data;
				else if (reg_index_t'(cfg_index) == REG_DAMPING)
					damping = cfg_data;
			end
			if (pair_valid && !pair_stall)
				force_q.push_back(contact_force(pair));
		end
	end
endmodule

// File: tb/tb.sv
// Testbench top for the disk contact force unit: stimulus, config phases and verdict.
`timescale 1ns / 1ps

module tb;
	import dcf_pkg::*;

	localparam int N_RANDOM = 800;
	localparam int SETTLE   = 90;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   pair_valid = 1'b0;
	logic                   pair_stall;
	pair_t                  pair = '0;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	result_t                res;
	logic                   cfg_wr_en = 1'b0;
	logic [REG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;
	int                     errors;
	int                     pending;
	bit                     quiet = 1'b0;

	always #10 clk = ~clk;

	disk_contact_force dut (.*);
	dcf_checker chk (.*);

	initial begin
		#20ms;
		$display("tb failed");
		$finish;
	end

	// result-side stall bursts
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 16);
				res_stall <= 1'b1;
				repeat (n) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic send_pair(pair_t p);
		int n;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 16);
			pair_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		pair_valid <= 1'b1;
		pair       <= p;
		do @(posedge clk); while (pair_stall);
		@(negedge clk);
	endtask

	task automatic drain;
		pair_valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_cfg(reg_index_t idx, logic [CFG_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic pair_t noise_pair();
		pair_t        p;
		logic [319:0] raw;
		raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom()};
		p = raw[$bits(pair_t)-1:0];
		return p;
	endfunction

	// pairs placed close enough that they mostly touch
	function automatic pair_t near_pair();
		pair_t p;
		int    sc;
		p  = noise_pair();
		sc = $urandom_range(2, 28);
		p.second_pos_x  = p.first_pos_x + ($signed($urandom()) >>> (32 - sc));
		p.second_pos_y  = p.first_pos_y + ($signed($urandom()) >>> (32 - sc));
		p.first_radius  = 31'($urandom()) >> (31 - sc);
		p.second_radius = 31'($urandom()) >> (31 - sc);
		if ($urandom_range(0, 3) == 0) begin
			p.second_vel_x = p.first_vel_x + ($signed($urandom()) >>> 8);
			p.second_vel_y = p.first_vel_y + ($signed($urandom()) >>> 8);
		end
		return p;
	endfunction

	function automatic pair_t make_pair(int px1, int py1, int px2, int py2,
			int r1, int r2, int vx, int vy);
		pair_t p;
		p = '0;
		p.first_pos_x   = px1;
		p.first_pos_y   = py1;
		p.second_pos_x  = px2;
		p.second_pos_y  = py2;
		p.first_radius  = 31'(r1);
		p.second_radius = 31'(r2);
		p.second_vel_x  = vx;
		p.second_vel_y  = vy;
		p.first_vel_x   = -vx;
		p.first_vel_y   = vy >>> 1;
		return p;
	endfunction

	initial begin
		localparam int ONE = 32'h0100_0000;
		localparam int MAXI = 32'h7fff_ffff;
		localparam int MINI = 32'h8000_0000;
		logic [CFG_W-1:0] k_set[6];
		logic [CFG_W-1:0] c_set[6];
		pair_t p;
		int    per;
		k_set = '{32'hffff_ffff, 32'd0, 32'h0001_0000, 32'h0040_0000, 32'hffff_ffff, 32'd0};
		c_set = '{32'hffff_ffff, 32'd0, 32'h0000_8000, 32'h0010_0000, 32'd0, 32'hffff_ffff};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset config first
		send_pair(make_pair(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0));            // coincident
		send_pair(make_pair(5, -7, 5, -7, MAXI, MAXI, MAXI, MINI));         // coincident, big radii
		send_pair(make_pair(0, 0, 4 * ONE, 0, ONE, ONE, 0, 0));             // apart
		send_pair(make_pair(0, 0, 2 * ONE, 0, ONE, ONE, 0, 0));             // just touching
		send_pair(make_pair(0, 0, ONE, 0, ONE, ONE, ONE, 0));               // along x
		send_pair(make_pair(0, 0, 0, -ONE, ONE, ONE, 0, MINI));             // along -y
		send_pair(make_pair(ONE, ONE, 0, 0, ONE, ONE, -ONE, ONE));          // diagonal
		send_pair(make_pair(MINI, MINI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI));
		send_pair(make_pair(MAXI, MINI, MINI, MAXI, MAXI, MAXI, MINI, MINI));
		send_pair(make_pair(0, 0, 1, 0, MAXI, MAXI, MAXI, MAXI));          // tiny distance
		send_pair(make_pair(0, 0, 1, 1, 0, 1, 0, 0));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
		drain();
		write_cfg(REG_SPRING, 32'hffff_ffff);
		write_cfg(REG_DAMPING, 32'hffff_ffff);
		send_pair(make_pair(MINI, 0, MAXI, 0, MAXI, MAXI, MAXI, 0));        // apart
		send_pair(make_pair(0, 0, ONE, ONE, 8 * ONE, 8 * ONE, MINI, MAXI));
		send_pair(make_pair(0, 0, -1, 0, MAXI, 0, MAXI, MAXI));
		drain();

		per = N_RANDOM / 6;
		for (int ph = 0; ph < 6; ph++) begin
			write_cfg(REG_SPRING, ph == 3 ? $urandom() : k_set[ph]);
			write_cfg(REG_DAMPING, ph == 3 ? $urandom() : c_set[ph]);
			for (int i = 0; i < per; i++) begin
				if (ph == 5 && i >= per / 2)
					quiet = 1'b1;
				case ($urandom_range(0, 9))
					0: p = noise_pair();
					1: begin
						p = noise_pair();
						p.second_pos_x = p.first_pos_x;
						p.second_pos_y = p.first_pos_y;
					end
					default: p = near_pair();
				endcase
				send_pair(p);
			end
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
